FILE: hdl/pptw_pkg.sv
package pptw_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;

  localparam int RANGE_BITS   = 16;
  localparam int BEARING_BITS = 16;
  localparam int POSE_BITS    = 24;
  localparam int HEAD_BITS    = 16;
  localparam int WORLD_BITS   = 25;
  localparam int CFG_IDX_BITS = 2;

  localparam int S_TDATA_BITS = 32;
  localparam int M_TDATA_BITS = 56;

  localparam int QBITS      = ANGLE_BITS - 2;
  localparam int PBITS      = QBITS + 1;
  localparam int FRAC_Q     = 30;
  localparam int XBITS      = 31;
  localparam int X2BITS     = 32;
  localparam int NBITS      = 32;
  localparam int RECIP_BITS = 30;
  localparam int QUOT_BITS  = 30;
  localparam int DIV_BITS   = 8;
  localparam int SUM_BITS   = 33;
  localparam int TRIG_BITS  = TRIG_FRAC_BITS + 2;
  localparam int NUM_TERMS  = 7;

  localparam int LANE_STAGES  = 4 + 3 * NUM_TERMS + 3;
  localparam int PLACE_STAGES = 2;
  localparam int NUM_STAGES   = 2 + LANE_STAGES + PLACE_STAGES;

  localparam logic [PBITS-1:0] QSIZE       = PBITS'(1) << QBITS;
  localparam logic [XBITS-1:0] HALF_PI_Q30 = 31'd1686629713;

  // taylor divisors (2k)(2k+1) and floor(2^32 / divisor)
  localparam logic [DIV_BITS-1:0] TERM_DIV [NUM_TERMS] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
  };
  localparam logic [RECIP_BITS-1:0] TERM_RECIP [NUM_TERMS] = '{
    30'(64'd4294967296 / 64'd6),
    30'(64'd4294967296 / 64'd20),
    30'(64'd4294967296 / 64'd42),
    30'(64'd4294967296 / 64'd72),
    30'(64'd4294967296 / 64'd110),
    30'(64'd4294967296 / 64'd156),
    30'(64'd4294967296 / 64'd210)
  };

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POSE_X       = 2'd0,
    CFG_POSE_Y       = 2'd1,
    CFG_POSE_HEADING = 2'd2
  } cfg_reg_e;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  function automatic logic [ANGLE_BITS-1:0] scale_angle(input logic [HEAD_BITS-1:0] theta);
    logic [ANGLE_BITS+HEAD_BITS-1:0] w;
    w = {theta, {ANGLE_BITS{1'b0}}};
    return w[ANGLE_BITS+HEAD_BITS-1:HEAD_BITS];
  endfunction

endpackage

FILE: hdl/pptw_sin_lane.sv
module pptw_sin_lane (
  input  logic                                clk_i,
  input  logic [pptw_pkg::LANE_STAGES-1:0]    en_i,
  input  logic [pptw_pkg::ANGLE_BITS-1:0]     angle_i,
  output pptw_pkg::trig_t                     trig_o
);

  localparam int LS   = pptw_pkg::LANE_STAGES;
  localparam int NT   = pptw_pkg::NUM_TERMS;
  localparam int XB   = pptw_pkg::XBITS;
  localparam int X2B  = pptw_pkg::X2BITS;
  localparam int NB   = pptw_pkg::NBITS;
  localparam int RB   = pptw_pkg::RECIP_BITS;
  localparam int QTB  = pptw_pkg::QUOT_BITS;
  localparam int DB   = pptw_pkg::DIV_BITS;
  localparam int SB   = pptw_pkg::SUM_BITS;
  localparam int FQ   = pptw_pkg::FRAC_Q;
  localparam int TFB  = pptw_pkg::TRIG_FRAC_BITS;
  localparam int PB   = pptw_pkg::PBITS;
  localparam int QB   = pptw_pkg::QBITS;
  localparam int XPB  = PB + XB;
  localparam int F0_STAGE = 4 + 3 * NT;

  localparam logic [FQ:0] ONE_Q30 = (FQ+1)'(1) << FQ;
  localparam logic [FQ:0] RND_Q30 = (FQ+1)'(1) << (FQ - 1 - TFB);

  // quadrant travels along with each item
  logic [1:0] quad_q [LS-1];

  logic [QB-1:0]        phase;
  logic [PB-1:0]        phase_m;
  logic [XPB-1:0]       xprod_q;
  logic [XB-1:0]        x_q;
  logic [2*XB-1:0]      xsq_q;
  logic [XB-1:0]        x_p2_q;
  logic [X2B-1:0]       p3_x2_q;
  logic [XB-1:0]        p3_term_q;
  logic signed [SB-1:0] p3_sum_q;

  logic [XB+X2B-1:0]    a_prod_q [NT];
  logic [X2B-1:0]       a_x2_q   [NT];
  logic signed [SB-1:0] a_sum_q  [NT];
  logic [NB+RB-1:0]     b_qm_q   [NT];
  logic [NB-1:0]        b_n_q    [NT];
  logic [X2B-1:0]       b_x2_q   [NT];
  logic signed [SB-1:0] b_sum_q  [NT];
  logic [XB-1:0]        c_term_q [NT];
  logic [X2B-1:0]       c_x2_q   [NT];
  logic signed [SB-1:0] c_sum_q  [NT];

  logic signed [SB-1:0] f0_sum_q;
  logic [FQ:0]          clamped;
  logic [FQ:0]          rounded;
  logic [TFB:0]         mag_q;
  logic signed [pptw_pkg::TRIG_BITS-1:0] mag_s;
  pptw_pkg::trig_t      trig_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quad_q[0] <= angle_i[pptw_pkg::ANGLE_BITS-1 -: 2];
    end
    for (int j = 1; j < LS - 1; j++) begin
      if (en_i[j]) begin
        quad_q[j] <= quad_q[j-1];
      end
    end
  end

  // mirror the phase in odd quadrants, scale to radians in q30
  always_comb begin
    phase   = angle_i[QB-1:0];
    phase_m = angle_i[QB] ? (pptw_pkg::QSIZE - {1'b0, phase}) : {1'b0, phase};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xprod_q <= XPB'(phase_m) * XPB'(pptw_pkg::HALF_PI_Q30);
    end
    if (en_i[1]) begin
      x_q <= XB'((xprod_q + XPB'(pptw_pkg::QSIZE >> 1)) >> QB);
    end
    if (en_i[2]) begin
      xsq_q  <= (2*XB)'(x_q) * (2*XB)'(x_q);
      x_p2_q <= x_q;
    end
    if (en_i[3]) begin
      p3_x2_q   <= xsq_q[FQ +: X2B];
      p3_term_q <= x_p2_q;
      p3_sum_q  <= $signed(SB'(x_p2_q));
    end
  end

  for (genvar k = 0; k < NT; k++) begin : g_term
    localparam int SA = 4 + 3 * k;

    logic [XB-1:0]        term_in;
    logic [X2B-1:0]       x2_in;
    logic signed [SB-1:0] sum_next;
    logic [QTB-1:0]       quot;
    logic [QTB+DB-1:0]    qd;
    logic [NB-1:0]        rem;
    logic                 corr;

    if (k == 0) begin : g_first
      assign term_in  = p3_term_q;
      assign x2_in    = p3_x2_q;
      assign sum_next = p3_sum_q;
    end else begin : g_rest
      assign term_in = c_term_q[k-1];
      assign x2_in   = c_x2_q[k-1];
      if (k % 2 == 1) begin : g_sub
        assign sum_next = c_sum_q[k-1] - $signed(SB'(c_term_q[k-1]));
      end else begin : g_add
        assign sum_next = c_sum_q[k-1] + $signed(SB'(c_term_q[k-1]));
      end
    end

    // exact floor division by the divisor: reciprocal estimate plus one fixup
    always_comb begin
      quot = b_qm_q[k][NB+RB-1:NB];
      qd   = (QTB+DB)'(quot) * (QTB+DB)'(pptw_pkg::TERM_DIV[k]);
      rem  = b_n_q[k] - qd[NB-1:0];
      corr = (rem >= NB'(pptw_pkg::TERM_DIV[k]));
    end

    always_ff @(posedge clk_i) begin
      if (en_i[SA]) begin
        a_prod_q[k] <= (XB+X2B)'(term_in) * (XB+X2B)'(x2_in);
        a_x2_q[k]   <= x2_in;
        a_sum_q[k]  <= sum_next;
      end
      if (en_i[SA+1]) begin
        b_qm_q[k]  <= (NB+RB)'(a_prod_q[k][FQ +: NB]) * (NB+RB)'(pptw_pkg::TERM_RECIP[k]);
        b_n_q[k]   <= a_prod_q[k][FQ +: NB];
        b_x2_q[k]  <= a_x2_q[k];
        b_sum_q[k] <= a_sum_q[k];
      end
      if (en_i[SA+2]) begin
        c_term_q[k] <= XB'(quot) + XB'(corr);
        c_x2_q[k]   <= b_x2_q[k];
        c_sum_q[k]  <= b_sum_q[k];
      end
    end
  end

  // last series term is odd, so it subtracts
  always_comb begin
    if (f0_sum_q < $signed(SB'(0))) begin
      clamped = '0;
    end else if (f0_sum_q > $signed(SB'(ONE_Q30))) begin
      clamped = ONE_Q30;
    end else begin
      clamped = f0_sum_q[FQ:0];
    end
    rounded = clamped + RND_Q30;
    mag_s   = $signed(pptw_pkg::TRIG_BITS'(mag_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[F0_STAGE]) begin
      f0_sum_q <= c_sum_q[NT-1] - $signed(SB'(c_term_q[NT-1]));
    end
    if (en_i[F0_STAGE+1]) begin
      mag_q <= rounded[FQ:FQ-TFB];
    end
    if (en_i[F0_STAGE+2]) begin
      trig_q <= quad_q[LS-2][1] ? -mag_s : mag_s;
    end
  end

  assign trig_o = trig_q;

endmodule

FILE: hdl/pptw_place.sv
module pptw_place (
  input  logic                                        clk_i,
  input  logic [pptw_pkg::PLACE_STAGES-1:0]           en_i,
  input  logic signed [pptw_pkg::POSE_BITS-1:0]       pose_i,
  input  logic [pptw_pkg::RANGE_BITS-1:0]             range_i,
  input  pptw_pkg::trig_t                             trig_i,
  output logic signed [pptw_pkg::WORLD_BITS-1:0]      world_o
);

  localparam int TFB = pptw_pkg::TRIG_FRAC_BITS;
  localparam int TB  = pptw_pkg::TRIG_BITS;
  localparam int RGB = pptw_pkg::RANGE_BITS;
  localparam int PSB = pptw_pkg::POSE_BITS;
  localparam int WB  = pptw_pkg::WORLD_BITS;
  localparam int PW  = RGB + 1 + TB;
  localparam int VW  = PSB + TFB + 2;

  logic signed [PW-1:0] range_s;
  logic signed [PW-1:0] trig_s;
  logic signed [PW-1:0] prod_q;
  logic signed [VW-1:0] acc;
  logic signed [WB-1:0] world_q;

  always_comb begin
    range_s = $signed({{(PW-RGB){1'b0}}, range_i});
    trig_s  = $signed({{(PW-TB){trig_i[TB-1]}}, trig_i});
    acc     = $signed({{2{pose_i[PSB-1]}}, pose_i, {TFB{1'b0}}})
            + $signed({{(VW-PW){prod_q[PW-1]}}, prod_q})
            + $signed(VW'(1) << (TFB - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= range_s * trig_s;
    end
    if (en_i[1]) begin
      world_q <= acc[TFB +: WB];
    end
  end

  assign world_o = world_q;

endmodule

FILE: hdl/polar_point_to_world_frame.sv
// throughput: one word per cycle while m_axis_tready does not stall the output
// the pipeline is 32 register stages with a valid bit each
// a stage loads whenever it is empty or its successor moves, so bubbles are squeezed out
// reset clears all valid bits and sets pose x, pose y and heading to zero
module polar_point_to_world_frame (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [pptw_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,  // range_mm, bearing
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [pptw_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,  // world_x, world_y, zero pad
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pptw_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [pptw_pkg::POSE_BITS-1:0]         cfg_data_i
);

  localparam int NS  = pptw_pkg::NUM_STAGES;
  localparam int LS  = pptw_pkg::LANE_STAGES;
  localparam int AB  = pptw_pkg::ANGLE_BITS;
  localparam int RGB = pptw_pkg::RANGE_BITS;
  localparam int BRB = pptw_pkg::BEARING_BITS;
  localparam int HB  = pptw_pkg::HEAD_BITS;
  localparam int PSB = pptw_pkg::POSE_BITS;
  localparam int WB  = pptw_pkg::WORLD_BITS;
  localparam int LANE_FIRST  = 2;
  localparam int PLACE_FIRST = LANE_FIRST + LS;

  localparam logic [AB-1:0] QUARTER = AB'(1) << pptw_pkg::QBITS;

  logic signed [PSB-1:0] pose_x_q;
  logic signed [PSB-1:0] pose_y_q;
  logic [HB-1:0]         heading_q;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] rdy;

  logic [RGB-1:0] range_q [NS-2];
  logic [BRB-1:0] bearing_q;
  logic [HB-1:0]  theta;
  logic [AB-1:0]  angle_s;
  logic [AB-1:0]  angle_s_q;
  logic [AB-1:0]  angle_c_q;

  pptw_pkg::trig_t   sin_v;
  pptw_pkg::trig_t   cos_v;
  logic signed [WB-1:0] world_x;
  logic signed [WB-1:0] world_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (pptw_pkg::cfg_reg_e'(cfg_index_i))
        pptw_pkg::CFG_POSE_X:       pose_x_q  <= $signed(cfg_data_i);
        pptw_pkg::CFG_POSE_Y:       pose_y_q  <= $signed(cfg_data_i);
        pptw_pkg::CFG_POSE_HEADING: heading_q <= cfg_data_i[HB-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain from the output register back to the input
  always_comb begin
    rdy[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_comb begin
    theta   = bearing_q + heading_q;
    angle_s = pptw_pkg::scale_angle(theta);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      range_q[0] <= s_axis_tdata[RGB-1:0];
      bearing_q  <= s_axis_tdata[RGB +: BRB];
    end
    for (int i = 1; i < NS - 2; i++) begin
      if (rdy[i]) begin
        range_q[i] <= range_q[i-1];
      end
    end
    if (rdy[1]) begin
      angle_s_q <= angle_s;
      angle_c_q <= angle_s + QUARTER;
    end
  end

  pptw_sin_lane u_sin_lane (
    .clk_i   (clk_i),
    .en_i    (rdy[LANE_FIRST +: LS]),
    .angle_i (angle_s_q),
    .trig_o  (sin_v)
  );

  pptw_sin_lane u_cos_lane (
    .clk_i   (clk_i),
    .en_i    (rdy[LANE_FIRST +: LS]),
    .angle_i (angle_c_q),
    .trig_o  (cos_v)
  );

  pptw_place u_place_x (
    .clk_i   (clk_i),
    .en_i    (rdy[PLACE_FIRST +: pptw_pkg::PLACE_STAGES]),
    .pose_i  (pose_x_q),
    .range_i (range_q[NS-3]),
    .trig_i  (cos_v),
    .world_o (world_x)
  );

  pptw_place u_place_y (
    .clk_i   (clk_i),
    .en_i    (rdy[PLACE_FIRST +: pptw_pkg::PLACE_STAGES]),
    .pose_i  (pose_y_q),
    .range_i (range_q[NS-3]),
    .trig_i  (sin_v),
    .world_o (world_y)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = valid_q[NS-1];
  assign m_axis_tdata  = {{(pptw_pkg::M_TDATA_BITS - 2*WB){1'b0}}, world_y, world_x};

endmodule
